>>> hdl/sdf_pkg.sv
// Shared types, codes and helpers for the spring-damper force accumulator.
// No dependencies; every other file of the block except sdf_ram imports this package.
package sdf_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int DATA_W    = 32;
    localparam int PARAM_W   = 31;
    localparam int CMD_W     = 3;
    localparam int VEC_W     = 3 * DATA_W;
    localparam int FRAC_BITS = 16;
    localparam int MUL_W     = 35;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = 64;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int CNT_W     = $clog2(SQRT_STEPS);
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int U_W       = Q_W + 1;
    localparam int ACC_W     = 52;
    localparam int SAT_W     = 50;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_POS  = 3'd0;
    localparam t_cmd CMD_VEL  = 3'd1;
    localparam t_cmd CMD_FRC  = 3'd2;
    localparam t_cmd CMD_CONN = 3'd3;
    localparam t_cmd CMD_READ = 3'd4;

    // datapath operations issued by the controller, one per cycle
    typedef logic [4:0] t_op;

    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LATCH     = 5'd1;
    localparam t_op OP_LOAD_WR   = 5'd2;
    localparam t_op OP_RD_A      = 5'd3;
    localparam t_op OP_RD_B      = 5'd4;
    localparam t_op OP_DELTA     = 5'd5;
    localparam t_op OP_SQ_MUL    = 5'd6;
    localparam t_op OP_SQ_ACC    = 5'd7;
    localparam t_op OP_SQRT_INIT = 5'd8;
    localparam t_op OP_SQRT_STEP = 5'd9;
    localparam t_op OP_DIV_INIT  = 5'd10;
    localparam t_op OP_DIV_STEP  = 5'd11;
    localparam t_op OP_DIV_SAVE  = 5'd12;
    localparam t_op OP_DOT_MUL   = 5'd13;
    localparam t_op OP_DOT_ACC   = 5'd14;
    localparam t_op OP_SPR_MUL   = 5'd15;
    localparam t_op OP_SPR_SAVE  = 5'd16;
    localparam t_op OP_DMP_MUL   = 5'd17;
    localparam t_op OP_FORCE     = 5'd18;
    localparam t_op OP_FC_MUL    = 5'd19;
    localparam t_op OP_FC_SAVE   = 5'd20;
    localparam t_op OP_ACC_WR_A  = 5'd21;
    localparam t_op OP_ACC_WR_B  = 5'd22;
    localparam t_op OP_OUT_LOAD  = 5'd23;

    typedef struct packed {
        t_cmd                      command;
        logic [NODE_W-1:0]         node_a;
        logic [NODE_W-1:0]         node_b;
        logic signed [DATA_W-1:0]  value_x;
        logic signed [DATA_W-1:0]  value_y;
        logic signed [DATA_W-1:0]  value_z;
        logic [PARAM_W-1:0]        rest_length;
        logic [PARAM_W-1:0]        stiffness;
        logic [PARAM_W-1:0]        damping;
        logic                      is_broken;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
    } t_out_word;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic broken;
        logic sqrt_last;
        logic div_last;
        logic dist_zero;
        logic out_free;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(64'sd2147483647);
        lo = SAT_W'(-64'sd2147483648);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

endpackage

>>> hdl/sdf_if.sv
// Valid/ready channel interfaces for command words and force words.
// Depends on sdf_pkg for field widths.
interface sdf_in_if;
    import sdf_pkg::*;
    logic                     valid;
    logic                     ready;
    t_cmd                     command;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [DATA_W-1:0] value_x;
    logic signed [DATA_W-1:0] value_y;
    logic signed [DATA_W-1:0] value_z;
    logic [PARAM_W-1:0]       rest_length;
    logic [PARAM_W-1:0]       stiffness;
    logic [PARAM_W-1:0]       damping;
    logic                     is_broken;

    modport source(output valid, command, node_a, node_b, value_x, value_y, value_z,
                   rest_length, stiffness, damping, is_broken, input ready);
    modport sink(input valid, command, node_a, node_b, value_x, value_y, value_z,
                 rest_length, stiffness, damping, is_broken, output ready);
endinterface

interface sdf_out_if;
    import sdf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;

    modport source(output valid, force_x, force_y, force_z, input ready);
    modport sink(input valid, force_x, force_y, force_z, output ready);
endinterface

>>> hdl/sdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sdf_ctrl.sv
// Sequencer for the force accumulator: walks each command through its datapath steps.
// Depends on sdf_pkg for operation codes and the control/status structs.
module sdf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sdf_pkg::t_stat i_stat,
    output sdf_pkg::t_ctrl o_ctrl
);
    import sdf_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_LOAD      = 5'd2;
    localparam logic [4:0] S_RD_A      = 5'd3;
    localparam logic [4:0] S_RD_B      = 5'd4;
    localparam logic [4:0] S_DELTA     = 5'd5;
    localparam logic [4:0] S_SQ_MUL    = 5'd6;
    localparam logic [4:0] S_SQ_ACC    = 5'd7;
    localparam logic [4:0] S_SQRT_INIT = 5'd8;
    localparam logic [4:0] S_SQRT      = 5'd9;
    localparam logic [4:0] S_DIST_CHK  = 5'd10;
    localparam logic [4:0] S_DIV_INIT  = 5'd11;
    localparam logic [4:0] S_DIV       = 5'd12;
    localparam logic [4:0] S_DIV_SAVE  = 5'd13;
    localparam logic [4:0] S_DOT_MUL   = 5'd14;
    localparam logic [4:0] S_DOT_ACC   = 5'd15;
    localparam logic [4:0] S_SPR_MUL   = 5'd16;
    localparam logic [4:0] S_SPR_SAVE  = 5'd17;
    localparam logic [4:0] S_DMP_MUL   = 5'd18;
    localparam logic [4:0] S_FORCE     = 5'd19;
    localparam logic [4:0] S_FC_MUL    = 5'd20;
    localparam logic [4:0] S_FC_SAVE   = 5'd21;
    localparam logic [4:0] S_ACC_RD_A  = 5'd22;
    localparam logic [4:0] S_ACC_WR_A  = 5'd23;
    localparam logic [4:0] S_ACC_RD_B  = 5'd24;
    localparam logic [4:0] S_ACC_WR_B  = 5'd25;
    localparam logic [4:0] S_RD_ISSUE  = 5'd26;
    localparam logic [4:0] S_RD_OUT    = 5'd27;

    logic [4:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    t_op        w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd) inside
                    CMD_POS, CMD_VEL, CMD_FRC: n_state = S_LOAD;
                    CMD_CONN: n_state = i_stat.broken ? S_IDLE : S_RD_A;
                    CMD_READ: n_state = S_RD_ISSUE;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_LOAD: begin
                w_op    = OP_LOAD_WR;
                n_state = S_IDLE;
            end
            S_RD_A: begin
                w_op    = OP_RD_A;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                w_op    = OP_RD_B;
                n_state = S_DELTA;
            end
            S_DELTA: begin
                w_op    = OP_DELTA;
                n_idx   = 2'd0;
                n_state = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                w_op    = OP_SQ_MUL;
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                w_op = OP_SQ_ACC;
                if (r_idx == 2'd2) begin
                    n_state = S_SQRT_INIT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_INIT: begin
                w_op    = OP_SQRT_INIT;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                w_op = OP_SQRT_STEP;
                if (i_stat.sqrt_last) begin
                    n_state = S_DIST_CHK;
                end
            end
            S_DIST_CHK: begin
                // coincident nodes give no force
                n_idx   = 2'd0;
                n_state = i_stat.dist_zero ? S_IDLE : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                w_op    = OP_DIV_INIT;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIV_SAVE;
                end
            end
            S_DIV_SAVE: begin
                w_op = OP_DIV_SAVE;
                if (r_idx == 2'd2) begin
                    n_idx   = 2'd0;
                    n_state = S_DOT_MUL;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_DOT_MUL: begin
                w_op    = OP_DOT_MUL;
                n_state = S_DOT_ACC;
            end
            S_DOT_ACC: begin
                w_op = OP_DOT_ACC;
                if (r_idx == 2'd2) begin
                    n_state = S_SPR_MUL;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_DOT_MUL;
                end
            end
            S_SPR_MUL: begin
                w_op    = OP_SPR_MUL;
                n_state = S_SPR_SAVE;
            end
            S_SPR_SAVE: begin
                w_op    = OP_SPR_SAVE;
                n_state = S_DMP_MUL;
            end
            S_DMP_MUL: begin
                w_op    = OP_DMP_MUL;
                n_state = S_FORCE;
            end
            S_FORCE: begin
                w_op    = OP_FORCE;
                n_idx   = 2'd0;
                n_state = S_FC_MUL;
            end
            S_FC_MUL: begin
                w_op    = OP_FC_MUL;
                n_state = S_FC_SAVE;
            end
            S_FC_SAVE: begin
                w_op = OP_FC_SAVE;
                if (r_idx == 2'd2) begin
                    n_idx   = 2'd0;
                    n_state = S_ACC_RD_A;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_FC_MUL;
                end
            end
            S_ACC_RD_A: begin
                w_op    = OP_RD_A;
                n_state = S_ACC_WR_A;
            end
            S_ACC_WR_A: begin
                w_op    = OP_ACC_WR_A;
                n_state = S_ACC_RD_B;
            end
            S_ACC_RD_B: begin
                w_op    = OP_RD_B;
                n_state = S_ACC_WR_B;
            end
            S_ACC_WR_B: begin
                w_op    = OP_ACC_WR_B;
                n_state = S_IDLE;
            end
            S_RD_ISSUE: begin
                w_op    = OP_RD_A;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    w_op    = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctrl.op  = w_op;
    assign o_ctrl.idx = r_idx;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");
    a_sqrt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && !i_stat.sqrt_last) |=> (r_state == S_SQRT))
        else $error("square root left early");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("component index out of range");
    a_save_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_SAVE) |-> ($past(r_state) == S_DIV))
        else $error("quotient saved without division");
`endif

endmodule

>>> hdl/sdf_dpath.sv
// Datapath: node memories, shared multiplier, square root and divider registers.
// Depends on sdf_pkg and sdf_ram.
module sdf_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdf_pkg::t_ctrl    i_ctrl,
    output sdf_pkg::t_stat    o_stat,
    input  sdf_pkg::t_in_word i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sdf_pkg::t_out_word o_out
);
    import sdf_pkg::*;

    t_in_word                 r_in;
    logic signed [DATA_W-1:0] r_pa [3];
    logic signed [DATA_W-1:0] r_va [3];
    logic signed [DATA_W-1:0] r_d  [3];
    logic signed [DATA_W-1:0] r_rv [3];
    logic signed [U_W-1:0]    r_u  [3];
    logic signed [33:0]       r_fc [3];
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         r_rem;
    logic [SUM_W-1:0]         r_root;
    logic [SUM_W-1:0]         r_bit;
    logic [DATA_W-1:0]        r_drem;
    logic [Q_W-1:0]           r_q;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [48:0]       r_spring;
    logic signed [DATA_W-1:0] r_f;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_out_valid;
    t_out_word                r_out;

    logic [VEC_W-1:0]         w_pos_rd, w_vel_rd, w_acc_rd;
    logic                     w_re;
    logic [NODE_W-1:0]        w_raddr;
    logic                     w_load;
    logic                     w_acc_we;
    logic [NODE_W-1:0]        w_acc_waddr;
    logic [VEC_W-1:0]         w_load_data;
    logic [VEC_W-1:0]         w_acc_wdata;
    logic [VEC_W-1:0]         w_acc_upd;
    logic signed [DATA_W-1:0] w_dlt [3];
    logic signed [DATA_W-1:0] w_rvl [3];
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic [DATA_W-1:0]        w_dist;
    logic [SUM_W-1:0]         w_sq_try;
    logic                     w_sq_ge;
    logic [DATA_W-1:0]        w_mag;
    logic                     w_ge0;
    logic [DATA_W:0]          w_dshift;
    logic                     w_dge;
    logic signed [MUL_W-1:0]  w_dot;
    logic signed [MUL_W-1:0]  w_stretch;
    logic signed [U_W-1:0]    w_uq;
    logic                     w_out_free;

    assign w_load      = (i_ctrl.op == OP_LOAD_WR);
    assign w_re        = (i_ctrl.op == OP_RD_A) || (i_ctrl.op == OP_RD_B);
    assign w_raddr     = (i_ctrl.op == OP_RD_B) ? r_in.node_b : r_in.node_a;
    assign w_load_data = {r_in.value_z, r_in.value_y, r_in.value_x};
    assign w_acc_we    = (w_load && r_in.command == CMD_FRC) || (i_ctrl.op == OP_ACC_WR_A)
                         || (i_ctrl.op == OP_ACC_WR_B);
    assign w_acc_waddr = (i_ctrl.op == OP_ACC_WR_B) ? r_in.node_b : r_in.node_a;
    assign w_acc_wdata = w_load ? w_load_data : w_acc_upd;

    sdf_ram #(.WIDTH(VEC_W), .DEPTH(MAX_NODES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_load && r_in.command == CMD_POS),
        .i_waddr (r_in.node_a),
        .i_wdata (w_load_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_pos_rd)
    );

    sdf_ram #(.WIDTH(VEC_W), .DEPTH(MAX_NODES)) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (w_load && r_in.command == CMD_VEL),
        .i_waddr (r_in.node_a),
        .i_wdata (w_load_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_vel_rd)
    );

    sdf_ram #(.WIDTH(VEC_W), .DEPTH(MAX_NODES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_acc_rd)
    );

    // node B data arrives while node A data sits in r_pa/r_va
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_dlt[c] = sat32(SAT_W'($signed({w_pos_rd[c*DATA_W+DATA_W-1], w_pos_rd[c*DATA_W+:DATA_W]}))
                             - SAT_W'(r_pa[c]));
            w_rvl[c] = sat32(SAT_W'($signed({w_vel_rd[c*DATA_W+DATA_W-1], w_vel_rd[c*DATA_W+:DATA_W]}))
                             - SAT_W'(r_va[c]));
            if (i_ctrl.op == OP_ACC_WR_B) begin
                w_acc_upd[c*DATA_W+:DATA_W] =
                    sat32(SAT_W'($signed(w_acc_rd[c*DATA_W+:DATA_W])) - SAT_W'(r_fc[c]));
            end else begin
                w_acc_upd[c*DATA_W+:DATA_W] =
                    sat32(SAT_W'($signed(w_acc_rd[c*DATA_W+:DATA_W])) + SAT_W'(r_fc[c]));
            end
        end
    end

    assign w_dist    = r_root[DATA_W-1:0];
    assign w_sq_try  = r_root + r_bit;
    assign w_sq_ge   = (r_rem >= w_sq_try);
    assign w_mag     = r_d[i_ctrl.idx][DATA_W-1] ? DATA_W'(-r_d[i_ctrl.idx]) : r_d[i_ctrl.idx];
    assign w_ge0     = (w_mag >= w_dist);
    assign w_dshift  = {r_drem, 1'b0};
    assign w_dge     = (w_dshift >= {1'b0, w_dist});
    assign w_uq      = $signed({1'b0, r_q});
    assign w_dot     = $signed(r_acc[MUL_W-1+FRAC_BITS:FRAC_BITS]);
    assign w_stretch = $signed({3'b000, w_dist}) - $signed({4'b0000, r_in.rest_length});

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_ctrl.op)
            OP_SQ_MUL: begin
                w_mul_a = MUL_W'(r_d[i_ctrl.idx]);
                w_mul_b = MUL_W'(r_d[i_ctrl.idx]);
            end
            OP_DOT_MUL: begin
                w_mul_a = MUL_W'(r_rv[i_ctrl.idx]);
                w_mul_b = MUL_W'(r_u[i_ctrl.idx]);
            end
            OP_SPR_MUL: begin
                w_mul_a = $signed({4'b0000, r_in.stiffness});
                w_mul_b = w_stretch;
            end
            OP_DMP_MUL: begin
                w_mul_a = $signed({4'b0000, r_in.damping});
                w_mul_b = w_dot;
            end
            OP_FC_MUL: begin
                w_mul_a = MUL_W'(r_f);
                w_mul_b = MUL_W'(r_u[i_ctrl.idx]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (i_ctrl.op)
            OP_LATCH: r_in <= i_in;
            OP_RD_B: begin
                for (int c = 0; c < 3; c++) begin
                    r_pa[c] <= $signed(w_pos_rd[c*DATA_W+:DATA_W]);
                    r_va[c] <= $signed(w_vel_rd[c*DATA_W+:DATA_W]);
                end
            end
            OP_DELTA: begin
                for (int c = 0; c < 3; c++) begin
                    r_d[c]  <= w_dlt[c];
                    r_rv[c] <= w_rvl[c];
                end
            end
            OP_SQ_ACC: r_sum <= ((i_ctrl.idx == 2'd0) ? '0 : r_sum) + r_prod[SUM_W-1:0];
            OP_SQRT_INIT: begin
                r_rem  <= r_sum;
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
            end
            OP_SQRT_STEP: begin
                if (w_sq_ge) begin
                    r_rem  <= r_rem - w_sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DIV_INIT: begin
                r_drem <= w_ge0 ? (w_mag - w_dist) : w_mag;
                r_q    <= Q_W'(w_ge0);
            end
            OP_DIV_STEP: begin
                r_drem <= w_dge ? DATA_W'(w_dshift - {1'b0, w_dist}) : w_dshift[DATA_W-1:0];
                r_q    <= {r_q[Q_W-2:0], w_dge};
            end
            // truncate toward zero: magnitude quotient takes the sign of the delta
            OP_DIV_SAVE: r_u[i_ctrl.idx] <= r_d[i_ctrl.idx][DATA_W-1] ? -w_uq : w_uq;
            OP_DOT_ACC: r_acc <= ((i_ctrl.idx == 2'd0) ? '0 : r_acc)
                                 + $signed(r_prod[ACC_W-1:0]);
            OP_SPR_SAVE: r_spring <= $signed(r_prod[48+FRAC_BITS:FRAC_BITS]);
            OP_FORCE: r_f <= sat32(SAT_W'(r_spring)
                                   + SAT_W'($signed(r_prod[48+FRAC_BITS:FRAC_BITS])));
            OP_FC_SAVE: r_fc[i_ctrl.idx] <= $signed(r_prod[33+FRAC_BITS:FRAC_BITS]);
            OP_OUT_LOAD: begin
                r_out.force_x <= $signed(w_acc_rd[0*DATA_W+:DATA_W]);
                r_out.force_y <= $signed(w_acc_rd[1*DATA_W+:DATA_W]);
                r_out.force_z <= $signed(w_acc_rd[2*DATA_W+:DATA_W]);
            end
            default: ;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_SQRT_INIT || i_ctrl.op == OP_DIV_INIT) begin
                r_cnt <= '0;
            end else if (i_ctrl.op == OP_SQRT_STEP || i_ctrl.op == OP_DIV_STEP) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_ctrl.op == OP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cmd       = r_in.command;
    assign o_stat.broken    = r_in.is_broken;
    assign o_stat.sqrt_last = (r_cnt == CNT_W'(SQRT_STEPS - 1));
    assign o_stat.div_last  = (r_cnt == CNT_W'(FRAC_BITS - 1));
    assign o_stat.dist_zero = (w_dist == '0);
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hdl/spring_damper_force_accumulator.sv
// Top level of the spring-damper force accumulator.
// Depends on sdf_pkg, sdf_if, sdf_ram, sdf_ctrl and sdf_dpath.
//
// Usage:
//   i_cmd carries one command word per handshake (valid/ready); o_force
//   returns one force word for each read command. Loads write a node's
//   position, velocity or initial force; a connection command adds the
//   spring-damper force to node A and subtracts it from node B, saturating.
//   A full connection is dominated by its 32 square-root steps and three
//   divisions on one shared divider; the rest are reads, a single shared
//   multiplier and the two accumulator updates. A read may also wait for
//   the output register. Broken connections and coincident nodes end early.
//   One word is processed at a time; the next word is taken while an
//   earlier force word still waits in the output register.
//   A stalled receiver holds the force word; a later read waits until the
//   output register frees up.
//   Reset (i_rst_n low, synchronous) clears the sequencer and output valid;
//   the node memories are not cleared and must be loaded before use.
module spring_damper_force_accumulator (
    input logic     i_clk,
    input logic     i_rst_n,
    sdf_in_if.sink  i_cmd,
    sdf_out_if.source o_force
);
    import sdf_pkg::*;

    t_ctrl     w_ctrl;
    t_stat     w_stat;
    t_in_word  w_in;
    t_out_word w_out;
    logic      w_ready;
    logic      w_out_valid;

    assign w_in.command     = i_cmd.command;
    assign w_in.node_a      = i_cmd.node_a;
    assign w_in.node_b      = i_cmd.node_b;
    assign w_in.value_x     = i_cmd.value_x;
    assign w_in.value_y     = i_cmd.value_y;
    assign w_in.value_z     = i_cmd.value_z;
    assign w_in.rest_length = i_cmd.rest_length;
    assign w_in.stiffness   = i_cmd.stiffness;
    assign w_in.damping     = i_cmd.damping;
    assign w_in.is_broken   = i_cmd.is_broken;
    assign i_cmd.ready      = w_ready;

    sdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    sdf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_in        (w_in),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_force.ready),
        .o_out       (w_out)
    );

    assign o_force.valid   = w_out_valid;
    assign o_force.force_x = w_out.force_x;
    assign o_force.force_y = w_out.force_y;
    assign o_force.force_z = w_out.force_z;

endmodule

>>> sim/tb_spring_damper_force_accumulator.sv
// Self-checking testbench for spring_damper_force_accumulator: directed and random
// command words, with a force predictor and random stalls on both channels.
// Depends on sdf_pkg, sdf_if and the block's RTL.
`timescale 1ns / 100ps

module tb_spring_damper_force_accumulator;
    import sdf_pkg::*;

    localparam t_cmd CMD_SPARE = 3'd5;   // first unused code, 5..7 are ignored
    localparam int   NUM_RANDOM = 870;

    logic i_clk;
    logic i_rst_n;

    sdf_in_if  cmd_if();
    sdf_out_if frc_if();

    spring_damper_force_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_force (frc_if)
    );

    // predicted node store
    logic signed [DATA_W-1:0] node_pos [MAX_NODES][3];
    logic signed [DATA_W-1:0] node_vel [MAX_NODES][3];
    logic signed [DATA_W-1:0] node_acc [MAX_NODES][3];
    bit pos_set [MAX_NODES];
    bit vel_set [MAX_NODES];
    bit acc_set [MAX_NODES];
    int live_nodes [$];    // nodes with position, velocity and force all loaded

    t_out_word pending_forces [$];
    int        error_count = 0;
    int        rx_hold = 0;
    bit        rx_no_stall = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = 64'h4000000000000000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    task automatic spring_force(input int a, input int b, input longint rest,
                                input longint stiff, input longint damp);
        longint dl [3];
        longint rv [3];
        longint uv [3];
        longint unsigned sq;
        longint span, dot, spr, dmp, f, fc;
        sq = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            dl[i] = clamp32(longint'(node_pos[b][i]) - longint'(node_pos[a][i]));
            rv[i] = clamp32(longint'(node_vel[b][i]) - longint'(node_vel[a][i]));
            sq += longint'(dl[i] * dl[i]);
        end
        span = longint'(root64(sq));
        if (span == 0) return;
        for (int i = 0; i < 3; i++) begin
            uv[i] = (dl[i] * 65536) / span;
            dot += rv[i] * uv[i];
        end
        dot = dot >>> FRAC_BITS;
        spr = (stiff * (span - rest)) >>> FRAC_BITS;
        dmp = (damp * dot) >>> FRAC_BITS;
        f = clamp32(spr + dmp);
        for (int i = 0; i < 3; i++) begin
            fc = (f * uv[i]) >>> FRAC_BITS;
            node_acc[a][i] = DATA_W'(clamp32(longint'(node_acc[a][i]) + fc));
            node_acc[b][i] = DATA_W'(clamp32(longint'(node_acc[b][i]) - fc));
        end
    endtask

    task automatic predict(input t_in_word w);
        int a;
        logic signed [DATA_W-1:0] v [3];
        a = w.node_a;
        v[0] = w.value_x;
        v[1] = w.value_y;
        v[2] = w.value_z;
        case (w.command)
            CMD_POS: begin
                node_pos[a] = v;
                pos_set[a] = 1;
            end
            CMD_VEL: begin
                node_vel[a] = v;
                vel_set[a] = 1;
            end
            CMD_FRC: begin
                node_acc[a] = v;
                acc_set[a] = 1;
            end
            CMD_CONN: begin
                if (!w.is_broken)
                    spring_force(a, w.node_b, longint'(w.rest_length),
                                 longint'(w.stiffness), longint'(w.damping));
            end
            CMD_READ: begin
                pending_forces.push_back('{node_acc[a][0], node_acc[a][1], node_acc[a][2]});
            end
            default: ;
        endcase
        if (w.command inside {CMD_POS, CMD_VEL, CMD_FRC} && pos_set[a] && vel_set[a]
            && acc_set[a]) begin
            int hits[$];
            hits = live_nodes.find_index with (item == a);
            if (hits.size() == 0) live_nodes.push_back(a);
        end
    endtask

    // gap: 0 keeps valid high into the next word
    task automatic send_word(input t_in_word w, input int gap);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= w.command;
        cmd_if.node_a      <= w.node_a;
        cmd_if.node_b      <= w.node_b;
        cmd_if.value_x     <= w.value_x;
        cmd_if.value_y     <= w.value_y;
        cmd_if.value_z     <= w.value_z;
        cmd_if.rest_length <= w.rest_length;
        cmd_if.stiffness   <= w.stiffness;
        cmd_if.damping     <= w.damping;
        cmd_if.is_broken   <= w.is_broken;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict(w);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 32'h04000000)) - 32'sh02000000);
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        case ($urandom_range(0, 3))
            0: return PARAM_W'($urandom());
            1: return PARAM_W'($urandom_range(0, 32'h00080000));
            2: return PARAM_W'($urandom_range(0, 32'h00010000));
            default: return PARAM_W'($urandom_range(0, 32'h01000000));
        endcase
    endfunction

    function automatic t_in_word load_word(input t_cmd c, input int n,
                                           input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
        t_in_word w;
        w = '0;
        w.command = c;
        w.node_a = NODE_W'(n);
        w.node_b = NODE_W'($urandom());
        w.value_x = x;
        w.value_y = y;
        w.value_z = z;
        w.rest_length = PARAM_W'($urandom());
        w.stiffness = PARAM_W'($urandom());
        w.damping = PARAM_W'($urandom());
        w.is_broken = 1'($urandom());
        return w;
    endfunction

    function automatic t_in_word conn_word(input int a, input int b, input logic brk,
                                           input logic [PARAM_W-1:0] rest,
                                           input logic [PARAM_W-1:0] stiff,
                                           input logic [PARAM_W-1:0] damp);
        t_in_word w;
        w = load_word(CMD_CONN, a, $urandom(), $urandom(), $urandom());
        w.node_b = NODE_W'(b);
        w.is_broken = brk;
        w.rest_length = rest;
        w.stiffness = stiff;
        w.damping = damp;
        return w;
    endfunction

    task automatic load_node(input int n, input int gap);
        send_word(load_word(CMD_POS, n, pick_value(), pick_value(), pick_value()), gap);
        send_word(load_word(CMD_VEL, n, pick_value(), pick_value(), pick_value()), gap);
        send_word(load_word(CMD_FRC, n, pick_value(), pick_value(), pick_value()), gap);
    endtask

    task automatic test_directed();
        localparam logic [31:0] MAXV = 32'h7FFFFFFF;
        localparam logic [31:0] MINV = 32'h80000000;
        send_word(load_word(CMD_POS, 0, MAXV, MINV, 32'h0), 0);
        send_word(load_word(CMD_VEL, 0, MINV, MAXV, 32'h00010000), 0);
        send_word(load_word(CMD_FRC, 0, MAXV, MINV, 32'hFFFF0000), 1);
        send_word(load_word(CMD_POS, 1023, MINV, MAXV, 32'h00030000), 0);
        send_word(load_word(CMD_VEL, 1023, MAXV, MINV, 32'h0), 0);
        send_word(load_word(CMD_FRC, 1023, MINV, MAXV, 32'h0), 0);
        send_word(load_word(CMD_READ, 0, 0, 0, 0), 0);
        send_word(load_word(CMD_READ, 1023, 0, 0, 0), 2);
        // saturated deltas, largest coefficients
        send_word(conn_word(0, 1023, 1'b0, '1, '1, '1), 0);
        send_word(conn_word(1023, 0, 1'b0, '0, '0, '0), 0);
        send_word(conn_word(0, 1023, 1'b1, '1, '1, '1), 0);
        // same node twice, then two nodes on one spot
        send_word(conn_word(1023, 1023, 1'b0, 31'h10000, 31'h10000, 31'h10000), 0);
        send_word(load_word(CMD_POS, 341, MAXV, MINV, 32'h0), 0);
        send_word(load_word(CMD_VEL, 341, 32'h00020000, 32'h0, 32'h0), 0);
        send_word(load_word(CMD_FRC, 341, 32'h0, 32'h0, 32'h0), 0);
        send_word(conn_word(0, 341, 1'b0, 31'h10000, 31'h20000, 31'h8000), 0);
        send_word(load_word(CMD_POS, 682, 32'h00050000, MINV, 32'h00010000), 0);
        send_word(load_word(CMD_VEL, 682, 32'h0, 32'h0, MAXV), 0);
        send_word(load_word(CMD_FRC, 682, 32'h00001000, 32'h0, 32'h0), 0);
        send_word(conn_word(341, 682, 1'b0, 31'h00018000, 31'h00040000, 31'h00002000), 3);
        for (int c = 0; c < 3; c++)
            send_word(load_word(t_cmd'(CMD_SPARE + c), 682, $urandom(), $urandom(),
                                $urandom()), 0);
        send_word(load_word(CMD_READ, 341, 0, 0, 0), 0);
        send_word(load_word(CMD_READ, 682, 0, 0, 0), 0);
        send_word(load_word(CMD_READ, 0, 0, 0, 0), 0);
    endtask

    task automatic test_random();
        int r, a, b;
        for (int i = 0; i < 12; i++) load_node($urandom_range(0, MAX_NODES - 1), pick_gap());
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if ((i % 150) == 0) rx_no_stall = ~rx_no_stall;
            r = $urandom_range(0, 99);
            a = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
            b = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
            if (r < 8) begin
                load_node($urandom_range(0, MAX_NODES - 1), pick_gap());
            end else if (r < 25) begin
                send_word(load_word(t_cmd'($urandom_range(CMD_POS, CMD_FRC)), a,
                                    pick_value(), pick_value(), pick_value()), pick_gap());
            end else if (r < 70) begin
                send_word(conn_word(a, ($urandom_range(0, 19) == 0) ? a : b,
                                    ($urandom_range(0, 9) == 0), pick_param(), pick_param(),
                                    pick_param()), pick_gap());
            end else if (r < 96) begin
                send_word(load_word(CMD_READ, a, $urandom(), $urandom(), $urandom()),
                          pick_gap());
            end else begin
                send_word(load_word(t_cmd'($urandom_range(CMD_SPARE, 7)),
                                    $urandom_range(0, MAX_NODES - 1), $urandom(),
                                    $urandom(), $urandom()), pick_gap());
            end
        end
    endtask

    // receiver holds off while reads keep coming
    task automatic test_backpressure();
        rx_hold = 400;
        for (int i = 0; i < 30; i++)
            send_word(load_word(CMD_READ, live_nodes[$urandom_range(0, live_nodes.size() - 1)],
                                0, 0, 0), 0);
    endtask

    // force word checker and receiver stalls
    initial begin
        int stall;
        t_out_word exp_w;
        stall = 0;
        frc_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && frc_if.valid && frc_if.ready) begin
                if (pending_forces.size() == 0) begin
                    $display("%t: unexpected force word %h %h %h", $realtime,
                             frc_if.force_x, frc_if.force_y, frc_if.force_z);
                    error_count++;
                end else begin
                    exp_w = pending_forces.pop_front();
                    if (frc_if.force_x !== exp_w.force_x) begin
                        $display("%t: force_x expected %h actual %h", $realtime,
                                 exp_w.force_x, frc_if.force_x);
                        error_count++;
                    end
                    if (frc_if.force_y !== exp_w.force_y) begin
                        $display("%t: force_y expected %h actual %h", $realtime,
                                 exp_w.force_y, frc_if.force_y);
                        error_count++;
                    end
                    if (frc_if.force_z !== exp_w.force_z) begin
                        $display("%t: force_z expected %h actual %h", $realtime,
                                 exp_w.force_z, frc_if.force_z);
                        error_count++;
                    end
                end
            end
            if (rx_hold > 0) begin
                frc_if.ready <= 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                frc_if.ready <= 1'b0;
                stall--;
            end else begin
                frc_if.ready <= 1'b1;
                if (!rx_no_stall) begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 25) stall = $urandom_range(1, 3);
                    else if (r < 28) stall = $urandom_range(20, 60);
                end
            end
        end
    end

    initial begin
        int guard;
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_POS;
        cmd_if.node_a = '0;
        cmd_if.node_b = '0;
        cmd_if.value_x = '0;
        cmd_if.value_y = '0;
        cmd_if.value_z = '0;
        cmd_if.rest_length = '0;
        cmd_if.stiffness = '0;
        cmd_if.damping = '0;
        cmd_if.is_broken = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        cmd_if.valid <= 1'b0;

        guard = 0;
        while (pending_forces.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (pending_forces.size() != 0) begin
            $display("%t: %0d force words never arrived", $realtime, pending_forces.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
